[src/assert_macros.svh]
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/rtk_pkg.sv]
package rtk_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int POS_W    = $clog2(MAX_LEN + 1);
  localparam int VALUE_W  = 32;
  localparam int K_W      = 8;
  localparam int COUNT_W  = 10;
  localparam int OUT_W    = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STORE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } store_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              hit;
    logic              sat;
  } scan_res_t;

endpackage

[src/rtk_entry_store.sv]
module rtk_entry_store (
  input  logic                                clk,
  input  logic                                rst,
  input  rtk_pkg::store_ctrl_t                ctrl,
  input  logic signed [rtk_pkg::VALUE_W-1:0]  wr_value,
  input  logic signed [rtk_pkg::VALUE_W-1:0]  key,
  input  logic [rtk_pkg::K_W-1:0]             limit_k,
  output rtk_pkg::scan_res_t                  res
);

  logic signed [rtk_pkg::VALUE_W-1:0] values [rtk_pkg::MAX_LEN];
  logic [rtk_pkg::K_W-1:0]            counters [rtk_pkg::MAX_LEN];

  logic signed [rtk_pkg::VALUE_W-1:0] sval;
  logic [rtk_pkg::K_W-1:0]            cnt;
  logic                               rvalid;
  logic [rtk_pkg::ADDR_W-1:0]         raddr;

  logic                               hit;
  logic [rtk_pkg::K_W-1:0]            cnt_new;
  logic                               cnt_we;
  logic [rtk_pkg::ADDR_W-1:0]         cnt_waddr;
  logic [rtk_pkg::K_W-1:0]            cnt_wdata;

  // single comparator: counter below limit and stored value strictly smaller
  assign hit     = rvalid && (cnt < limit_k) && (sval < key);
  assign cnt_new = hit ? cnt + rtk_pkg::K_W'(1) : cnt;

  always_comb begin
    cnt_we    = ctrl.wr_en || hit;
    cnt_waddr = ctrl.wr_en ? ctrl.wr_addr : raddr;
    cnt_wdata = ctrl.wr_en ? '0 : cnt_new;
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      values[ctrl.wr_addr] <= wr_value;
    end
    if (ctrl.rd_en) begin
      sval <= values[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counters[cnt_waddr] <= cnt_wdata;
    end
    if (ctrl.rd_en) begin
      cnt <= counters[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= ctrl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      raddr <= ctrl.rd_addr;
    end
  end

  always_comb begin
    res.valid = rvalid;
    res.addr  = raddr;
    res.hit   = hit;
    res.sat   = cnt_new >= limit_k;
  end

endmodule

[src/range_topk_unary_encoder.sv]
// Channel   Dir  tdata                      tuser
// s_axis    in   [31:0] value (signed)      [0] first
// m_axis    out  [9:0] count, [15:10] zero  [0] overflow
// cfg       in   cfg_wdata[7:0] limit_k on cfg_we
//
// First item of a sequence and a dropped item (store full) are handled in idle without a scan.
// Any other item scans entries start..position-1 through one comparator,
// one entry per cycle, then stores the item and gives its result.
// rst clears position, start pointer and output valid; limit_k resets to 1.
// s_axis_tready is low while scanning or storing, or while a result is held on m_axis.
module range_topk_unary_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [0:0]  s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] count, [15:10] zero
  output logic [0:0]  m_axis_tuser,   // [0] overflow
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  rtk_pkg::state_t state, state_next;

  logic [rtk_pkg::POS_W-1:0]          pos, pos_next;
  logic [rtk_pkg::POS_W-1:0]          sp, sp_next;
  logic [rtk_pkg::POS_W-1:0]          raddr, raddr_next;
  logic                               prefix, prefix_next;
  logic [rtk_pkg::COUNT_W-1:0]        count, count_next;
  logic signed [rtk_pkg::VALUE_W-1:0] key, key_next;
  logic [rtk_pkg::K_W-1:0]            limit_k;
  logic                               out_valid, out_valid_next;
  logic [rtk_pkg::COUNT_W-1:0]        out_count, out_count_next;
  logic                               out_ovf, out_ovf_next;

  logic                               accept;
  logic [rtk_pkg::POS_W-1:0]          eff_pos;
  logic [rtk_pkg::POS_W-1:0]          eff_sp;
  logic                               rd_more;
  logic signed [rtk_pkg::VALUE_W-1:0] wr_value;

  rtk_pkg::store_ctrl_t               ctrl;
  rtk_pkg::scan_res_t                 res;

  assign s_axis_tready = (state == rtk_pkg::ST_IDLE) && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign eff_pos       = s_axis_tuser[0] ? '0 : pos;
  assign eff_sp        = s_axis_tuser[0] ? '0 : sp;
  assign rd_more       = raddr < pos;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(rtk_pkg::OUT_W - rtk_pkg::COUNT_W){1'b0}}, out_count};
  assign m_axis_tuser  = out_ovf;

  rtk_entry_store u_store (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .wr_value (wr_value),
    .key      (key),
    .limit_k  (limit_k),
    .res      (res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rtk_pkg::ST_IDLE: begin
        if (accept && (eff_pos != '0) && (eff_pos < rtk_pkg::POS_W'(rtk_pkg::MAX_LEN))) begin
          state_next = rtk_pkg::ST_SCAN;
        end
      end
      rtk_pkg::ST_SCAN: begin
        if (!rd_more && !res.valid) begin
          state_next = rtk_pkg::ST_STORE;
        end
      end
      rtk_pkg::ST_STORE: state_next = rtk_pkg::ST_IDLE;
      default:           state_next = rtk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pos_next       = pos;
    sp_next        = sp;
    raddr_next     = raddr;
    prefix_next    = prefix;
    count_next     = count;
    key_next       = key;
    out_valid_next = out_valid && !m_axis_tready;
    out_count_next = out_count;
    out_ovf_next   = out_ovf;
    ctrl           = '0;
    wr_value       = key;
    unique case (state)
      rtk_pkg::ST_IDLE: begin
        if (accept) begin
          sp_next = eff_sp;
          if (eff_pos == '0) begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = '0;
            wr_value     = s_axis_tdata;
            pos_next     = rtk_pkg::POS_W'(1);
          end else if (eff_pos >= rtk_pkg::POS_W'(rtk_pkg::MAX_LEN)) begin
            out_valid_next = 1'b1;
            out_count_next = '0;
            out_ovf_next   = 1'b1;
          end else begin
            pos_next    = eff_pos;
            key_next    = s_axis_tdata;
            raddr_next  = eff_sp;
            prefix_next = 1'b1;
            count_next  = '0;
          end
        end
      end
      rtk_pkg::ST_SCAN: begin
        if (rd_more) begin
          ctrl.rd_en   = 1'b1;
          ctrl.rd_addr = raddr[rtk_pkg::ADDR_W-1:0];
          raddr_next   = raddr + rtk_pkg::POS_W'(1);
        end
        if (res.valid) begin
          if (res.hit) begin
            count_next = count + rtk_pkg::COUNT_W'(1);
          end
          // start pointer follows the leading run of saturated entries
          if (prefix && res.sat) begin
            sp_next = rtk_pkg::POS_W'(res.addr) + rtk_pkg::POS_W'(1);
          end else begin
            prefix_next = 1'b0;
          end
        end
      end
      rtk_pkg::ST_STORE: begin
        ctrl.wr_en     = 1'b1;
        ctrl.wr_addr   = pos[rtk_pkg::ADDR_W-1:0];
        pos_next       = pos + rtk_pkg::POS_W'(1);
        out_valid_next = 1'b1;
        out_count_next = count;
        out_ovf_next   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rtk_pkg::ST_IDLE;
      pos       <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
      limit_k   <= rtk_pkg::K_W'(1);
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      sp        <= sp_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        limit_k <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr     <= raddr_next;
    prefix    <= prefix_next;
    count     <= count_next;
    key       <= key_next;
    out_count <= out_count_next;
    out_ovf   <= out_ovf_next;
  end

endmodule

[src/rtk_checker.sv]
`include "assert_macros.svh"

module rtk_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic        in_xfer;
  logic        out_stall;
  logic        ovf_valid;
  logic        count_zero;
  logic        pad_zero;
  logic        no_scan_out;
  logic [16:0] out_word;

  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign ovf_valid   = m_axis_tvalid && m_axis_tuser[0];
  assign count_zero  = m_axis_tdata[9:0] == 10'd0;
  assign pad_zero    = m_axis_tdata[15:10] == 6'd0;
  assign no_scan_out = !m_axis_tvalid || m_axis_tuser[0];
  assign out_word    = {m_axis_tuser, m_axis_tdata};

  `ASSERT_IMP(a_ovf_zero_count, clk, rst, ovf_valid, count_zero, "overflow with nonzero count")
  `ASSERT_IMP(a_pad_zero, clk, rst, m_axis_tvalid, pad_zero, "tdata padding not zero")
  `ASSERT_NXT(a_no_early_result, clk, rst, in_xfer, no_scan_out, "early scan result")
  `ASSERT_NXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(out_word), "result not held")

endmodule

bind range_topk_unary_encoder rtk_checker u_rtk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
